// ----- rtl/mcd_pkg.sv -----
// Shared types and codes for the multi-cycle control decoder.
// Holds the control word layout, the opcode, function and ALU op codes, and the reset word.
// No dependencies.
package mcd_pkg;

    typedef struct packed {
        logic [3:0] alu_operation;
        logic       alu_source_a;
        logic [1:0] alu_source_b;
        logic [1:0] pc_source;
        logic       pc_write;
        logic       pc_write_conditional;
        logic       register_write;
        logic       register_destination;
        logic       memory_to_register;
        logic       save_return_address;
        logic [3:0] memory_flags;
        logic       sign_extend;
    } ctl_word_t;

    // Cycle phases.
    localparam logic [2:0] PH_DECODE    = 3'd1;
    localparam logic [2:0] PH_EXECUTE   = 3'd2;
    localparam logic [2:0] PH_MEMORY    = 3'd3;
    localparam logic [2:0] PH_WRITEBACK = 3'd4;

    // Opcodes.
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDI_U  = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTI_U  = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SW      = 6'h2B;

    // R-type function codes.
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_SRA  = 6'h03;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_XOR  = 6'h26;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLT  = 6'h2A;
    localparam logic [5:0] FN_SLTU = 6'h2B;

    // ALU operation codes.
    localparam logic [3:0] ALU_ADD   = 4'd0;
    localparam logic [3:0] ALU_SUB   = 4'd1;
    localparam logic [3:0] ALU_AND   = 4'd2;
    localparam logic [3:0] ALU_OR    = 4'd3;
    localparam logic [3:0] ALU_XOR   = 4'd4;
    localparam logic [3:0] ALU_NOR   = 4'd5;
    localparam logic [3:0] ALU_SLT   = 4'd6;
    localparam logic [3:0] ALU_SLT_U = 4'd7;
    localparam logic [3:0] ALU_SLL   = 4'd8;
    localparam logic [3:0] ALU_SRL   = 4'd9;
    localparam logic [3:0] ALU_SRA   = 4'd10;
    localparam logic [3:0] ALU_LUI   = 4'd11;
    localparam logic [3:0] ALU_EQ    = 4'd12;
    localparam logic [3:0] ALU_NEQ   = 4'd13;
    localparam logic [3:0] ALU_NONE  = 4'b1111;

    // Memory flag bits.
    localparam int MEM_READ_BIT  = 0;
    localparam int MEM_WRITE_BIT = 1;
    localparam int MEM_DATA_BIT  = 2;
    localparam int MEM_IR_BIT    = 3;

    localparam ctl_word_t CTL_RESET = '{
        alu_operation:        ALU_NONE,
        alu_source_a:         1'b0,
        alu_source_b:         2'd0,
        pc_source:            2'd0,
        pc_write:             1'b0,
        pc_write_conditional: 1'b0,
        register_write:       1'b0,
        register_destination: 1'b0,
        memory_to_register:   1'b0,
        save_return_address:  1'b0,
        memory_flags:         4'd0,
        sign_extend:          1'b1
    };

endpackage

// ----- rtl/mcd_decode.sv -----
// Next-word logic of the control decoder: applies one opcode, function and phase
// to the current control word. Purely combinational; depends on mcd_pkg.
module mcd_decode
    import mcd_pkg::*;
(
    input  ctl_word_t  cur_word,
    input  logic [5:0] operation_code,
    input  logic [5:0] function_code,
    input  logic [2:0] cycle_phase,
    output ctl_word_t  next_word
);

    ctl_word_t dflt;
    logic [3:0] rtype_op;
    logic [3:0] itype_op;
    logic       is_jr;
    logic       is_zext;
    logic       is_load;
    logic       is_store;

    // Defaults keep the link flag; only reset clears it.
    always_comb begin
        dflt = CTL_RESET;
        dflt.save_return_address = cur_word.save_return_address;
    end

    assign is_jr    = (function_code == FN_JR);
    assign is_zext  = (operation_code == OP_ANDI) || (operation_code == OP_ORI) ||
                      (operation_code == OP_XORI);
    assign is_load  = (operation_code == OP_LW);
    assign is_store = (operation_code == OP_SW);

    always_comb begin
        unique case (function_code)
            FN_SLL:  rtype_op = ALU_SLL;
            FN_SRL:  rtype_op = ALU_SRL;
            FN_SRA:  rtype_op = ALU_SRA;
            FN_ADDU: rtype_op = ALU_ADD;
            FN_SUBU: rtype_op = ALU_SUB;
            FN_AND:  rtype_op = ALU_AND;
            FN_OR:   rtype_op = ALU_OR;
            FN_XOR:  rtype_op = ALU_XOR;
            FN_NOR:  rtype_op = ALU_NOR;
            FN_SLT:  rtype_op = ALU_SLT;
            FN_SLTU: rtype_op = ALU_SLT_U;
            default: rtype_op = ALU_NONE;
        endcase
    end

    always_comb begin
        unique case (operation_code)
            OP_SLTI:   itype_op = ALU_SLT;
            OP_SLTI_U: itype_op = ALU_SLT_U;
            OP_ANDI:   itype_op = ALU_AND;
            OP_ORI:    itype_op = ALU_OR;
            OP_XORI:   itype_op = ALU_XOR;
            OP_LUI:    itype_op = ALU_LUI;
            default:   itype_op = ALU_ADD;
        endcase
    end

    always_comb begin
        next_word = cur_word;
        unique case (operation_code)
            OP_SPECIAL: begin
                unique case (cycle_phase)
                    PH_DECODE: begin
                        if (is_jr) begin
                            next_word.pc_write = 1'b0;
                        end
                    end
                    PH_EXECUTE: begin
                        next_word = dflt;
                        next_word.alu_source_a = 1'b1;
                        next_word.alu_source_b = 2'd0;
                        next_word.alu_operation = rtype_op;
                        next_word.pc_write = is_jr;
                    end
                    PH_MEMORY: next_word = dflt;
                    PH_WRITEBACK: begin
                        next_word = dflt;
                        next_word.register_destination = 1'b1;
                        next_word.register_write = !is_jr;
                    end
                    default: ;
                endcase
            end
            OP_J: begin
                if (cycle_phase == PH_DECODE) begin
                    next_word.pc_source = 2'd2;
                    next_word.pc_write = 1'b1;
                end
            end
            OP_JAL: begin
                unique case (cycle_phase)
                    PH_DECODE: next_word.pc_write = 1'b0;
                    PH_WRITEBACK: begin
                        next_word = dflt;
                        next_word.pc_source = 2'd2;
                        next_word.pc_write = 1'b1;
                        next_word.register_write = 1'b1;
                        next_word.save_return_address = 1'b1;
                    end
                    default: ;
                endcase
            end
            OP_BEQ, OP_BNE: begin
                unique case (cycle_phase)
                    PH_DECODE: begin
                        next_word.alu_source_a = 1'b0;
                        next_word.alu_source_b = 2'd3;
                        next_word.pc_source = 2'd1;
                        next_word.pc_write = 1'b0;
                    end
                    PH_EXECUTE: begin
                        next_word = dflt;
                        next_word.alu_operation =
                            (operation_code == OP_BEQ) ? ALU_EQ : ALU_NEQ;
                        next_word.alu_source_a = 1'b1;
                        next_word.alu_source_b = 2'd0;
                        next_word.pc_write_conditional = 1'b1;
                    end
                    default: ;
                endcase
            end
            OP_ADDI_U, OP_SLTI, OP_SLTI_U, OP_ANDI, OP_ORI, OP_XORI, OP_LUI,
            OP_LW, OP_SW: begin
                unique case (cycle_phase)
                    PH_DECODE: begin
                        if (is_zext) begin
                            next_word.sign_extend = 1'b0;
                        end
                    end
                    PH_EXECUTE: begin
                        next_word = dflt;
                        next_word.alu_source_a = 1'b1;
                        next_word.alu_source_b = 2'd2;
                        next_word.alu_operation = itype_op;
                    end
                    PH_MEMORY: begin
                        next_word = dflt;
                        next_word.memory_flags[MEM_READ_BIT]  = is_load;
                        next_word.memory_flags[MEM_WRITE_BIT] = is_store;
                        next_word.memory_flags[MEM_DATA_BIT]  = is_load || is_store;
                    end
                    PH_WRITEBACK: begin
                        next_word = dflt;
                        next_word.register_write = !is_store;
                        next_word.memory_to_register = is_load;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

endmodule

// ----- rtl/multicycle_control_decoder_top.sv -----
// Top level of the multi-cycle control decoder: input register, next-word logic, and
// the control word register that also serves as the result register. Depends on mcd_pkg
// and mcd_decode.
//
// Each input beat (opcode, function code, cycle phase) updates the stored control word and
// returns the whole updated word as one result beat. A beat is captured in an input
// register, and the decode logic writes the new word into the result register when that
// register is empty or being drained; the result is then presented. While results
// drain, a new beat can be taken every cycle; while a result waits for m_ready, one more
// beat is held in the input register and s_ready then follows m_ready. The stored word
// only changes when a beat passes into the result register, so the order of beats alone
// decides the results. After reset the word holds the defaults: ALU op none, sign
// extension on, all else zero.
module multicycle_control_decoder_top
    import mcd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [5:0] s_operation_code,
    input  logic [5:0] s_function_code,
    input  logic [2:0] s_cycle_phase,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_alu_operation,
    output logic       m_alu_source_a,
    output logic [1:0] m_alu_source_b,
    output logic [1:0] m_pc_source,
    output logic       m_pc_write,
    output logic       m_pc_write_conditional,
    output logic       m_register_write,
    output logic       m_register_destination,
    output logic       m_memory_to_register,
    output logic       m_save_return_address,
    output logic [3:0] m_memory_flags,
    output logic       m_sign_extend
);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [5:0] op_reg;
    logic [5:0] fn_reg;
    logic [2:0] phase_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    ctl_word_t  control_word_reg;
    ctl_word_t  control_word_next;
    logic       s_fire;
    logic       advance;

    // A held beat moves on when the result register is empty or being drained.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    mcd_decode u_decode (
        .cur_word       (control_word_reg),
        .operation_code (op_reg),
        .function_code  (fn_reg),
        .cycle_phase    (phase_reg),
        .next_word      (control_word_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            control_word_reg <= CTL_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                control_word_reg <= control_word_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg    <= s_operation_code;
            fn_reg    <= s_function_code;
            phase_reg <= s_cycle_phase;
        end
    end

    assign m_valid                = out_valid_reg;
    assign m_alu_operation        = control_word_reg.alu_operation;
    assign m_alu_source_a         = control_word_reg.alu_source_a;
    assign m_alu_source_b         = control_word_reg.alu_source_b;
    assign m_pc_source            = control_word_reg.pc_source;
    assign m_pc_write             = control_word_reg.pc_write;
    assign m_pc_write_conditional = control_word_reg.pc_write_conditional;
    assign m_register_write       = control_word_reg.register_write;
    assign m_register_destination = control_word_reg.register_destination;
    assign m_memory_to_register   = control_word_reg.memory_to_register;
    assign m_save_return_address  = control_word_reg.save_return_address;
    assign m_memory_flags         = control_word_reg.memory_flags;
    assign m_sign_extend          = control_word_reg.sign_extend;

    // The link flag is sticky; only reset may clear it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> !$fell(control_word_reg.save_return_address))
        else $error("link flag cleared without reset");

    // No rule sets the instruction register write bit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !control_word_reg.memory_flags[MEM_IR_BIT])
        else $error("instruction register write bit set");

    // The stored word only changes when a beat passes into the result register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(control_word_reg))
        else $error("control word changed without a beat");

    // A beat passing into the result register is always presented.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("result beat lost");

endmodule
